@@ rtl/core/shell_neighborhood_type_counter_top_assert.svh @@
// Assertion macros shared by the counter RTL
`ifndef SHELL_NEIGHBORHOOD_TYPE_COUNTER_TOP_ASSERT_SVH
`define SHELL_NEIGHBORHOOD_TYPE_COUNTER_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define SNC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/snc_pkg.sv @@
`default_nettype none
package snc_pkg;
  localparam int unsigned MaxAtomsDef = 1024;
  localparam int unsigned MaxNbrDef   = 16;

  localparam logic [1:0] OP_SLOT  = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [2:0] REG_SHELL_DEPTH  = 3'd0;
  localparam logic [2:0] REG_RANGE_COUNT  = 3'd1;
  localparam logic [2:0] REG_RANGE0_START = 3'd2;
  localparam logic [2:0] REG_RANGE0_END   = 3'd3;
  localparam logic [2:0] REG_RANGE1_START = 3'd4;
  localparam logic [2:0] REG_RANGE1_END   = 3'd5;
  localparam logic [2:0] REG_RANGE2_START = 3'd6;
  localparam logic [2:0] REG_RANGE2_END   = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  atom;
    logic [3:0]  slot;
    logic [9:0]  neighbor_atom;
    logic [4:0]  neighbor_total;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  range_index;
    logic [10:0] atom_count;
    logic [10:0] cluster_size;
    logic        last;
  } out_word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_item;   // capture input word
    logic wr_slot;     // write adjacency slot
    logic wr_count;    // write neighbor count
    logic clr_init;    // start clear sweep
    logic clr_step;    // clear one visited entry
    logic seed;        // mark center, frontier = {center}
    logic shell_init;  // swap frontiers, reset indices
    logic fr_read;     // read frontier entry
    logic cnt_read;    // read neighbor count
    logic adj_read;    // read adjacency slot
    logic vis_read;    // read visited of neighbor
    logic vis_mark;    // mark and append neighbor
    logic j_inc;
    logic i_inc;
    logic rng_init;    // start scan of a range
    logic rng_read;    // read visited at scan index
    logic rng_acc;     // accumulate
    logic emit;        // strobe result
    logic rng_next;
  } snc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic item_ok;     // write/query target in range
    logic fr_empty;    // next frontier empty
    logic i_done;      // all frontier entries walked
    logic j_done;      // all slots of atom walked
    logic nb_ok;       // neighbor index in table
    logic nb_new;      // neighbor not yet visited
    logic depth_done;
    logic scan_done;
    logic rng_last;
  } snc_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/snc_ram.sv @@
`default_nettype none
module snc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/snc_ctrl.sv @@
`default_nettype none
module snc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire snc_pkg::in_word_t in_word,
  input  wire snc_pkg::snc_sts_t sts,
  output logic                   busy,
  output snc_pkg::snc_cmd_t      cmd
);
  import snc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CLEAR, S_SEED, S_SHELL, S_FR_RD, S_FR_WAIT, S_CNT_RD,
    S_CNT_WAIT, S_ADJ_RD, S_ADJ_WAIT, S_VIS_RD, S_VIS_WAIT, S_VIS_CHK,
    S_RNG_INIT, S_RNG_RD, S_RNG_WAIT, S_RNG_ACC, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  assign busy = busy_r;

  always_comb begin
    state_nxt    = state_r;
    busy_nxt     = busy_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          busy_nxt      = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
        case (in_word.opcode)
          OP_SLOT:  cmd.wr_slot = sts.item_ok;
          OP_COUNT: cmd.wr_count = sts.item_ok;
          OP_QUERY: begin
            if (sts.item_ok) begin
              cmd.clr_init = 1'b1;
              busy_nxt     = 1'b1;
              state_nxt    = S_CLEAR;
            end
          end
          default: ;
        endcase
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_SHELL;
      end
      S_SHELL: begin
        if (sts.depth_done || sts.fr_empty) begin
          state_nxt = S_RNG_INIT;
        end else begin
          cmd.shell_init = 1'b1;
          state_nxt      = S_FR_RD;
        end
      end
      S_FR_RD: begin
        if (sts.i_done) begin
          state_nxt = S_SHELL;
        end else begin
          cmd.fr_read = 1'b1;
          state_nxt   = S_FR_WAIT;
        end
      end
      S_FR_WAIT: state_nxt = S_CNT_RD;
      S_CNT_RD: begin
        cmd.cnt_read = 1'b1;
        state_nxt    = S_CNT_WAIT;
      end
      S_CNT_WAIT: state_nxt = S_ADJ_RD;
      S_ADJ_RD: begin
        if (sts.j_done) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_FR_RD;
        end else begin
          cmd.adj_read = 1'b1;
          state_nxt    = S_ADJ_WAIT;
        end
      end
      S_ADJ_WAIT: state_nxt = S_VIS_RD;
      S_VIS_RD: begin
        cmd.vis_read = 1'b1;
        state_nxt    = S_VIS_WAIT;
      end
      S_VIS_WAIT: state_nxt = S_VIS_CHK;
      S_VIS_CHK: begin
        cmd.vis_mark = sts.nb_ok && sts.nb_new;
        cmd.j_inc    = 1'b1;
        state_nxt    = S_ADJ_RD;
      end
      S_RNG_INIT: begin
        cmd.rng_init = 1'b1;
        state_nxt    = S_RNG_RD;
      end
      S_RNG_RD: begin
        // one entry per pass: read, wait, accumulate
        if (sts.scan_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.rng_read = 1'b1;
          state_nxt    = S_RNG_WAIT;
        end
      end
      S_RNG_WAIT: begin
        // hold the scan address on the visited read port
        cmd.rng_read = 1'b1;
        state_nxt    = S_RNG_ACC;
      end
      S_RNG_ACC: begin
        cmd.rng_acc  = 1'b1;
        state_nxt    = S_RNG_RD;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.rng_last) begin
          busy_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          cmd.rng_next = 1'b1;
          state_nxt    = S_RNG_INIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      busy_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      busy_r     <= busy_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/snc_dpath.sv @@
`default_nettype none
module snc_dpath #(
  parameter int unsigned MAX_ATOMS     = snc_pkg::MaxAtomsDef,
  parameter int unsigned MAX_NEIGHBORS = snc_pkg::MaxNbrDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire snc_pkg::in_word_t  in_word,
  input  wire snc_pkg::snc_cmd_t  cmd,
  input  wire logic [3:0]         shell_depth,
  input  wire logic [1:0]         range_count,
  input  wire logic [10:0]        rng_start [3],
  input  wire logic [10:0]        rng_end [3],
  output snc_pkg::snc_sts_t       sts,
  output snc_pkg::in_word_t       item,
  output logic                    out_valid,
  output snc_pkg::out_word_t      out_word
);
  import snc_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_ATOMS);
  localparam int unsigned SW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned CW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned LW  = $clog2(MAX_ATOMS + 1);
  localparam int unsigned ADJ_DEPTH = MAX_ATOMS * MAX_NEIGHBORS;
  localparam int unsigned ADW = $clog2(ADJ_DEPTH);

  in_word_t item_r;
  assign item = item_r;

  // item range checks
  logic atom_ok, slot_ok;
  assign atom_ok = ({22'd0, item_r.atom} < 32'(MAX_ATOMS));
  assign slot_ok = ({28'd0, item_r.slot} < 32'(MAX_NEIGHBORS));

  // counters and registers
  logic [LW-1:0]  clr_idx_r;
  logic [3:0]     shell_r;
  logic [LW-1:0]  fr_len_r, nxt_len_r, i_r;
  logic           sel_r;     // which frontier bank holds current
  logic [AW-1:0]  cur_atom_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  j_r;
  logic [9:0]     nb_r;
  logic [10:0]    size_r;
  logic [1:0]     rng_r;
  logic [11:0]    scan_r;
  logic [11:0]    scan_end_r;
  logic [10:0]    acc_r;

  // memories
  logic [9:0]    adj_rd;
  logic [CW-1:0] cnt_rd;
  logic [0:0]    vis_rd;
  logic [AW-1:0] fr_rd [2];

  logic [ADW-1:0] adj_waddr, adj_raddr;
  assign adj_waddr = ADW'(item_r.atom[AW-1:0]) * ADW'(MAX_NEIGHBORS)
                   + ADW'(item_r.slot);
  assign adj_raddr = ADW'(cur_atom_r) * ADW'(MAX_NEIGHBORS) + ADW'(j_r);

  snc_ram #(.WIDTH(10), .DEPTH(ADJ_DEPTH)) u_adj (
    .clk(clk), .we(cmd.wr_slot), .waddr(adj_waddr), .wdata(item_r.neighbor_atom),
    .raddr(adj_raddr), .rdata(adj_rd)
  );

  logic [CW-1:0] tot_sat;
  assign tot_sat = ({27'd0, item_r.neighbor_total} > 32'(MAX_NEIGHBORS))
                 ? CW'(MAX_NEIGHBORS) : CW'(item_r.neighbor_total);

  snc_ram #(.WIDTH(CW), .DEPTH(MAX_ATOMS)) u_cnt (
    .clk(clk), .we(cmd.wr_count), .waddr(item_r.atom[AW-1:0]), .wdata(tot_sat),
    .raddr(cur_atom_r), .rdata(cnt_rd)
  );

  // visited bitmap: one write port serves clear, seed and mark
  logic          vis_we;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic [0:0]    vis_wdata;
  always_comb begin
    vis_we    = cmd.clr_step || cmd.seed || cmd.vis_mark;
    vis_waddr = nb_r[AW-1:0];
    vis_wdata = 1'b1;
    if (cmd.clr_step) begin
      vis_waddr = clr_idx_r[AW-1:0];
      vis_wdata = 1'b0;
    end else if (cmd.seed) begin
      vis_waddr = item_r.atom[AW-1:0];
    end
    vis_raddr = cmd.rng_read ? scan_r[AW-1:0] : nb_r[AW-1:0];
  end

  snc_ram #(.WIDTH(1), .DEPTH(MAX_ATOMS)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rd)
  );

  // two frontier banks, swapped each shell
  logic nxt_full;
  assign nxt_full = (nxt_len_r == LW'(MAX_ATOMS));
  for (genvar b = 0; b < 2; b++) begin : g_fr
    logic          we_b;
    logic [AW-1:0] wa_b;
    logic [AW-1:0] wd_b;
    always_comb begin
      we_b = 1'b0;
      wa_b = nxt_len_r[AW-1:0];
      wd_b = nb_r[AW-1:0];
      if (cmd.seed && b == 0) begin
        we_b = 1'b1;
        wa_b = '0;
        wd_b = item_r.atom[AW-1:0];
      end else if (cmd.vis_mark && !nxt_full && (sel_r != 1'(b))) begin
        we_b = 1'b1;
      end
    end
    snc_ram #(.WIDTH(AW), .DEPTH(MAX_ATOMS)) u_fr (
      .clk(clk), .we(we_b), .waddr(wa_b), .wdata(wd_b),
      .raddr(i_r[AW-1:0]), .rdata(fr_rd[b])
    );
  end

  logic [11:0] rs_w, re_w, re_cap;
  always_comb begin
    rs_w   = {1'b0, rng_start[rng_r]};
    re_w   = {1'b0, rng_end[rng_r]};
    re_cap = (re_w > 12'(MAX_ATOMS)) ? 12'(MAX_ATOMS) : re_w;
  end

  logic [1:0] nr;
  assign nr = (range_count == 2'd0) ? 2'd1 : range_count;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_word;
    end
    if (cmd.clr_init) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
    if (cmd.seed) begin
      sel_r     <= 1'b1;   // shell_init flips to bank zero
      nxt_len_r <= LW'(1);
      shell_r   <= '0;
      size_r    <= 11'd1;
      fr_len_r  <= LW'(1);
    end
    if (cmd.shell_init) begin
      sel_r     <= ~sel_r;
      fr_len_r  <= nxt_len_r;
      nxt_len_r <= '0;
      i_r       <= '0;
      shell_r   <= shell_r + 1'b1;
    end
    if (cmd.cnt_read) begin
      cur_atom_r <= fr_rd[sel_r];
      j_r        <= '0;
    end
    if (cmd.adj_read) begin
      cnt_r <= cnt_rd;
    end
    if (cmd.vis_read) begin
      nb_r <= adj_rd;
    end
    if (cmd.vis_mark) begin
      size_r <= size_r + 1'b1;
      if (!nxt_full) begin
        nxt_len_r <= nxt_len_r + 1'b1;
      end
    end
    if (cmd.j_inc) begin
      j_r <= j_r + 1'b1;
    end
    if (cmd.i_inc) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.rng_init) begin
      scan_r     <= rs_w;
      scan_end_r <= (rs_w < re_w) ? re_cap : rs_w;
      acc_r      <= '0;
    end
    if (cmd.rng_acc) begin
      acc_r  <= acc_r + 11'(vis_rd);
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.emit) begin
      out_word.range_index <= rng_r;
      out_word.atom_count  <= acc_r;
      out_word.cluster_size <= size_r;
      out_word.last        <= (rng_r + 2'd1 == nr);
    end
    if (!rst_n) begin
      rng_r <= '0;
    end else if (cmd.emit) begin
      rng_r <= cmd.rng_next ? rng_r + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  // frontier entry fetched on the cnt_read cycle; count fetched the cycle after
  // cnt_r is valid once the first slot read decides; j_done uses the ram output
  // on the first pass through S_ADJ_RD, then the held copy
  logic [CW-1:0] cnt_cur;
  logic          first_j;
  assign first_j = (j_r == '0);
  assign cnt_cur = first_j ? cnt_rd : cnt_r;

  always_comb begin
    sts            = '0;
    sts.clr_done   = (clr_idx_r == LW'(MAX_ATOMS - 1));
    sts.item_ok    = atom_ok && ((item_r.opcode != OP_SLOT) || slot_ok);
    sts.fr_empty   = (nxt_len_r == '0);
    sts.i_done     = (i_r == fr_len_r);
    sts.j_done     = (j_r >= cnt_cur);
    sts.nb_ok      = ({22'd0, nb_r} < 32'(MAX_ATOMS));
    sts.nb_new     = (vis_rd == 1'b0);
    sts.depth_done = (shell_r >= shell_depth);
    sts.scan_done  = (scan_r >= scan_end_r);
    sts.rng_last   = (rng_r + 2'd1 == nr);
  end
endmodule
`default_nettype wire

@@ rtl/core/shell_neighborhood_type_counter_top.sv @@
// A write or an ignored word is decoded and done; a query clears the visited map,
// seeds the center, walks each shell frontier atom by atom and each atom's
// neighbor slots one by one, then per counted range scans the atom indices;
// each result is registered before it leaves on out_valid.
// Results come one per range on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) restores register defaults and idles the FSM.
`default_nettype none
`include "shell_neighborhood_type_counter_top_assert.svh"
module shell_neighborhood_type_counter_top #(
  parameter int unsigned MAX_ATOMS     = snc_pkg::MaxAtomsDef,
  parameter int unsigned MAX_NEIGHBORS = snc_pkg::MaxNbrDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire snc_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output snc_pkg::out_word_t      out_word,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [10:0]        cfg_data
);
  import snc_pkg::*;

  logic [3:0]  shell_depth_r;
  logic [1:0]  range_count_r;
  logic [10:0] rng_start_r [3];
  logic [10:0] rng_end_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shell_depth_r <= 4'd1;
      range_count_r <= 2'd1;
      for (int k = 0; k < 3; k++) begin
        rng_start_r[k] <= '0;
        rng_end_r[k]   <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHELL_DEPTH:  shell_depth_r <= cfg_data[3:0];
        REG_RANGE_COUNT:  range_count_r <= cfg_data[1:0];
        REG_RANGE0_START: rng_start_r[0] <= cfg_data;
        REG_RANGE0_END:   rng_end_r[0]   <= cfg_data;
        REG_RANGE1_START: rng_start_r[1] <= cfg_data;
        REG_RANGE1_END:   rng_end_r[1]   <= cfg_data;
        REG_RANGE2_START: rng_start_r[2] <= cfg_data;
        REG_RANGE2_END:   rng_end_r[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  snc_cmd_t cmd;
  snc_sts_t sts;
  in_word_t item;

  snc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(item), .sts(sts),
    .busy(busy), .cmd(cmd)
  );

  snc_dpath #(.MAX_ATOMS(MAX_ATOMS), .MAX_NEIGHBORS(MAX_NEIGHBORS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .cmd(cmd),
    .shell_depth(shell_depth_r), .range_count(range_count_r),
    .rng_start(rng_start_r), .rng_end(rng_end_r), .sts(sts), .item(item),
    .out_valid(out_valid), .out_word(out_word)
  );

  `SNC_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, $past(busy), "result outside a query")
  `SNC_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_word.last, !out_valid, "result after last")
  `SNC_ASSERT_IMP(a_size_pos, clk, rst_n, out_valid, out_word.cluster_size != 11'd0, "empty cluster")
endmodule
`default_nettype wire
